// ----- rtl/lsfr_pkg.sv -----
// Shared type and constant for the limited-slope face reconstruction core.
package lsfr_pkg;

  // Longest grid line the cell counter tracks; the counter saturates below it.
  localparam int MaxCells = 4096;

  // Job handed from the front part to the divider part.
  typedef struct packed {
    logic        do_div;    // same-sign nonzero differences
    logic        neg;       // both differences negative
    logic [32:0] mag_a;     // |up|
    logic [32:0] mag_b;     // |um|
    logic        emit;      // a face word results
    logic [32:0] left_sum;  // older + previous half-slope, unsaturated
    logic [31:0] prev;      // previous sample
    logic [11:0] face;      // face index
  } job_t;

endpackage

// ----- rtl/limited_slope_face_reconstruction_core.sv -----
// Top level of the limited-slope face reconstruction core.
// Usage:
//   Input channel: sample_i / first_of_row_i words with in_valid / in_stall.
//   first_of_row_i restarts the window; cells 0..2 of a line give no word.
//   Output channel: left_state_o, right_state_o, face_index_o words with
//   out_valid / out_stall; one word per cell from the fourth onward.
//   Each word runs through the back part: a 33x33 multiply of the two
//   difference magnitudes, then, when the slopes agree in sign, a 66-step
//   restoring divide by their sum, one quotient bit per cycle.
//   The divider loop sets the rate.
//   The front stalls the next input word until the half-slope of the
//   current one returns, as the next face needs it.
//   Reset clears the window, counter and all valid flags.
//   A stalled output word holds; the back part waits in its final state
//   and the front stalls behind it.
module limited_slope_face_reconstruction_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] sample_i,
  input  logic        first_of_row_i,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] left_state_o,
  output logic [31:0] right_state_o,
  output logic [11:0] face_index_o
);
  lsfr_pkg::job_t job;
  logic job_valid, job_stall, hs_valid;
  logic [31:0] hs;

  lsfr_front u_front (
    .clk_i, .rst_ni, .in_valid, .in_stall, .sample_i, .first_of_row_i,
    .hs_i(hs), .hs_valid_i(hs_valid),
    .job_valid_o(job_valid), .job_stall_i(job_stall), .job_o(job)
  );

  lsfr_back u_back (
    .clk_i, .rst_ni, .job_valid_i(job_valid), .job_stall_o(job_stall),
    .job_i(job), .hs_o(hs), .hs_valid_o(hs_valid),
    .out_valid, .out_stall, .left_state_o, .right_state_o, .face_index_o
  );
endmodule

// ----- rtl/lsfr_front.sv -----
// Front part: sample window, differences and job classification.
module lsfr_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [31:0]     sample_i,
  input  logic            first_of_row_i,
  input  logic [31:0]     hs_i,       // half-slope of the previous cell
  input  logic            hs_valid_i, // back part delivered it
  output logic            job_valid_o,
  input  logic            job_stall_i,
  output lsfr_pkg::job_t  job_o
);
  localparam logic [11:0] CntMax = 12'(lsfr_pkg::MaxCells - 1);

  logic [31:0] prev_q, older_q, phs_q;
  logic [11:0] cnt_q;
  logic        busy_q;  // a job is out, its half-slope not yet back

  logic [11:0] c;
  logic [32:0] up, um;
  logic        pos, neg, acc;

  always_comb begin
    c   = first_of_row_i ? '0 : cnt_q;
    up  = {sample_i[31], sample_i} - {prev_q[31], prev_q};
    um  = {prev_q[31], prev_q} - {older_q[31], older_q};
    pos = (c >= 12'd2) && !up[32] && (up != '0) && !um[32] && (um != '0);
    neg = (c >= 12'd2) && up[32] && um[32];
    in_stall = busy_q || job_stall_i;
    acc = in_valid && !in_stall;
    job_valid_o        = in_valid && !busy_q;
    job_o.do_div       = pos || neg;
    job_o.neg          = neg;
    job_o.mag_a        = up[32] ? -up : up;
    job_o.mag_b        = um[32] ? -um : um;
    job_o.emit         = c >= 12'd3;
    job_o.left_sum     = {older_q[31], older_q} + {phs_q[31], phs_q};
    job_o.prev         = prev_q;
    job_o.face         = c - 12'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0; older_q <= '0; phs_q <= '0; cnt_q <= '0; busy_q <= 1'b0;
    end else begin
      if (acc) begin
        older_q <= prev_q;
        prev_q  <= sample_i;
        busy_q  <= 1'b1;
        cnt_q   <= (c < CntMax) ? c + 12'd1 : c;
      end
      if (hs_valid_i) begin
        phs_q  <= hs_i;
        busy_q <= 1'b0;
      end
    end
  end
endmodule

// ----- rtl/lsfr_back.sv -----
// Back part: job register, multiply, radix-2 divide, output register.
module lsfr_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            job_valid_i,
  output logic            job_stall_o,
  input  lsfr_pkg::job_t  job_i,
  output logic [31:0]     hs_o,
  output logic            hs_valid_o,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [31:0]     left_state_o,
  output logic [31:0]     right_state_o,
  output logic [11:0]     face_index_o
);
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_MUL = 4'b0010, S_DIV = 4'b0100, S_DONE = 4'b1000
  } state_e;

  state_e         st_q, st_d;
  lsfr_pkg::job_t job_q;
  logic [65:0]    prod_q;   // shifts in quotient bits as dividend drains
  logic [33:0]    den_q;
  logic [34:0]    rem_q;
  logic [6:0]     step_q;

  logic [34:0] rem_sh, rem_sub;
  logic [32:0] hs_full, r_full;
  logic [31:0] l_sat, r_sat;
  logic        out_free;  // output register can take a word this cycle

  function automatic logic [31:0] sat33(input logic [32:0] v);
    if (v[32] != v[31]) return v[32] ? 32'h8000_0000 : 32'h7fff_ffff;
    return v[31:0];
  endfunction

  always_comb begin
    rem_sh  = {rem_q[33:0], prod_q[65]};
    rem_sub = rem_sh - {1'b0, den_q};
    hs_full = job_q.neg ? -{1'b0, prod_q[31:0]} : {1'b0, prod_q[31:0]};
    r_full  = {job_q.prev[31], job_q.prev} - (job_q.do_div ? hs_full : 33'd0);
    l_sat   = sat33(job_q.left_sum);
    r_sat   = sat33(r_full);
    out_free = !out_valid || !out_stall;
    job_stall_o = (st_q != S_IDLE);
    st_d = st_q;
    unique case (st_q)
      S_IDLE: if (job_valid_i) st_d = S_MUL;
      S_MUL:  st_d = job_q.do_div ? S_DIV : S_DONE;
      S_DIV:  if (step_q == 7'd65) st_d = S_DONE;
      S_DONE: if (out_free) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  assign hs_o       = job_q.do_div ? hs_full[31:0] : 32'd0;
  assign hs_valid_o = (st_q == S_DONE) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; out_valid <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == S_DONE && out_free && job_q.emit) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      S_IDLE: if (job_valid_i) job_q <= job_i;
      S_MUL: begin
        prod_q <= {33'd0, job_q.mag_a} * {33'd0, job_q.mag_b};
        den_q  <= {1'b0, job_q.mag_a} + {1'b0, job_q.mag_b};
        rem_q  <= '0;
        step_q <= '0;
      end
      S_DIV: begin
        step_q <= step_q + 7'd1;
        if (rem_sh >= {1'b0, den_q}) begin
          rem_q  <= rem_sub;
          prod_q <= {prod_q[64:0], 1'b1};
        end else begin
          rem_q  <= rem_sh;
          prod_q <= {prod_q[64:0], 1'b0};
        end
      end
      S_DONE: begin
        if (out_free && job_q.emit) begin
          left_state_o  <= l_sat;
          right_state_o <= r_sat;
          face_index_o  <= job_q.face;
        end
      end
      default: ;
    endcase
  end
endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the limited-slope face reconstruction core.
`timescale 1ns / 1ps

module tb_top;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] sample_i = '0;
  logic        first_of_row_i = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] left_state_o;
  logic [31:0] right_state_o;
  logic [11:0] face_index_o;

  limited_slope_face_reconstruction_core uut (
    .clk_i, .rst_ni, .in_valid, .in_stall, .sample_i, .first_of_row_i,
    .out_valid, .out_stall, .left_state_o, .right_state_o, .face_index_o
  );

  always #4 clk_i = ~clk_i;

  typedef struct packed {
    logic [31:0] sample;
    logic        first;
  } cell_word_t;

  typedef struct packed {
    logic [31:0] left;
    logic [31:0] right;
    logic [11:0] face;
  } face_word_t;

  localparam int MaxCells  = 4096;
  localparam int WatchLim  = 20000;
  localparam int LongHold  = 600;

  // Words waiting to be sent, and face words still owed by the core.
  cell_word_t pending_cells[$];
  face_word_t owed_faces[$];

  // Predictor state: the window of the current grid line.
  longint     win_prev, win_older, win_prev_half;
  int unsigned win_count;
  int         fail_count = 0;
  int         sent_count = 0;
  bit         all_queued = 1'b0;
  bit         hold_rx = 1'b0;       // long receiver hold-off request
  bit         hold_tx = 1'b0;       // sender drain pause request

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Harmonic van Leer half-slope, truncated toward zero.
  function automatic longint van_leer_half(longint up, longint um);
    logic [127:0] prod;
    logic [127:0] quo;
    logic [63:0]  a, b;
    bit pos, neg;
    pos = up > 0 && um > 0;
    neg = up < 0 && um < 0;
    if (!pos && !neg) return 0;
    a = pos ? up : -up;
    b = pos ? um : -um;
    prod = {64'd0, a} * {64'd0, b};
    quo = prod / {64'd0, a + b};
    return pos ? longint'(quo[63:0]) : -longint'(quo[63:0]);
  endfunction

  // Advance the window by one cell and record the face word it yields.
  task automatic predict_face(input cell_word_t w);
    longint s, h;
    face_word_t f;
    s = longint'($signed(w.sample));
    h = 0;
    if (w.first) win_count = 0;
    if (win_count >= 2) h = van_leer_half(s - win_prev, win_prev - win_older);
    if (win_count >= 3) begin
      f.left  = 32'(sat32(win_older + win_prev_half));
      f.right = 32'(sat32(win_prev - h));
      f.face  = 12'(win_count - 1);
      owed_faces.push_back(f);
    end
    win_older = win_prev;
    win_prev = s;
    win_prev_half = h;
    if (win_count < MaxCells - 1) win_count++;
  endtask

  // Driver: draw a gap per word, hold the payload until accepted.
  int tx_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall) begin
        predict_face('{sample_i, first_of_row_i});
        sent_count <= sent_count + 1;
      end
      if (!in_valid || !in_stall) begin
        if (in_valid && !in_stall) tx_gap = $urandom_range(0, 10) * ($urandom_range(0, 3) != 0);
        if (tx_gap > 0 || hold_tx || pending_cells.size() == 0) begin
          if (tx_gap > 0) tx_gap--;
          in_valid <= 1'b0;
        end else begin
          cell_word_t w;
          w = pending_cells.pop_front();
          sample_i <= w.sample;
          first_of_row_i <= w.first;
          in_valid <= 1'b1;
        end
      end
    end
  end

  // Monitor: compare each accepted face word with the oldest owed one.
  int rx_gap = 0;
  int rx_hold_cnt = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        if (owed_faces.size() == 0) begin
          $error("face word with none owed: face %0d", face_index_o);
          fail_count++;
        end else begin
          face_word_t f;
          f = owed_faces.pop_front();
          if (left_state_o !== f.left) begin
            $error("left_state exp %h got %h", f.left, left_state_o);
            fail_count++;
          end
          if (right_state_o !== f.right) begin
            $error("right_state exp %h got %h", f.right, right_state_o);
            fail_count++;
          end
          if (face_index_o !== f.face) begin
            $error("face_index exp %0d got %0d", f.face, face_index_o);
            fail_count++;
          end
        end
        rx_gap = $urandom_range(0, 10) * ($urandom_range(0, 3) != 0);
      end
      if (hold_rx && rx_hold_cnt < LongHold) begin
        rx_hold_cnt++;
        out_stall <= 1'b1;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: cycles with no word moving on either side.
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLim) begin
      $display("** limited_slope_face_reconstruction_core: FAILED **");
      $finish;
    end
  end

  function automatic logic [31:0] rand_sample(int mode);
    case (mode)
      0: return $urandom();
      1: return $urandom_range(0, 8) - 4;
      2: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom())};
      default: return $urandom_range(0, 1) ? 32'h7fffffff - $urandom_range(0, 3)
                                           : 32'h80000000 + $urandom_range(0, 3);
    endcase
  endfunction

  task automatic push_line(int len, int mode);
    logic [31:0] base;
    base = rand_sample(mode);
    for (int i = 0; i < len; i++) begin
      // Mostly smooth ramps with random bumps, so both limiter branches fire.
      if ($urandom_range(0, 2) == 0) base = rand_sample(mode);
      else base = base + rand_sample(1) * (mode == 1 ? 1 : 32'd4096);
      pending_cells.push_back('{base, i == 0});
    end
  endtask

  task automatic wait_drained;
    wait (pending_cells.size() == 0 && !in_valid && owed_faces.size() == 0);
    repeat (100) @(posedge clk_i);
  endtask

  initial begin
    win_prev = 0; win_older = 0; win_prev_half = 0; win_count = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: no row flag after reset, then extremes and sign patterns.
    pending_cells.push_back('{32'h00010000, 1'b0});
    pending_cells.push_back('{32'h00020000, 1'b0});
    pending_cells.push_back('{32'h00040000, 1'b0});
    pending_cells.push_back('{32'h00050000, 1'b0});
    pending_cells.push_back('{32'h00030000, 1'b0});
    pending_cells.push_back('{32'h00030000, 1'b0});
    pending_cells.push_back('{32'h7fffffff, 1'b0});
    pending_cells.push_back('{32'h80000000, 1'b0});
    pending_cells.push_back('{32'h7fffffff, 1'b0});
    pending_cells.push_back('{32'h80000000, 1'b1});   // ascending extremes
    pending_cells.push_back('{32'hc0000000, 1'b0});
    pending_cells.push_back('{32'h00000000, 1'b0});
    pending_cells.push_back('{32'h7fffffff, 1'b0});
    pending_cells.push_back('{32'hffffffff, 1'b0});
    pending_cells.push_back('{32'h00000005, 1'b1});   // short line, discarded
    pending_cells.push_back('{32'h00000009, 1'b0});
    pending_cells.push_back('{32'hfffffff0, 1'b1});
    pending_cells.push_back('{32'hfffffff8, 1'b0});
    pending_cells.push_back('{32'hfffffffc, 1'b0});
    pending_cells.push_back('{32'hfffffffe, 1'b0});
    pending_cells.push_back('{32'hffffffff, 1'b0});
    wait_drained();

    // Long receiver hold-off while the sender keeps offering words.
    push_line(60, 2);
    hold_rx = 1'b1;
    wait_drained();
    hold_rx = 1'b0;

    // Random lines, mostly well formed; occasional drain pauses.
    while (sent_count < 1600) begin
      push_line($urandom_range(1, 40), $urandom_range(0, 3));
      if ($urandom_range(0, 30) == 0) begin
        hold_tx = 1'b1;
        wait (owed_faces.size() == 0 && !in_valid);
        hold_tx = 1'b0;
      end
      wait (pending_cells.size() < 8);
    end
    wait_drained();

    if (fail_count == 0) $display("** limited_slope_face_reconstruction_core: PASSED **");
    else $display("** limited_slope_face_reconstruction_core: FAILED **");
    $finish;
  end

endmodule
